@@ src/teta_pkg.sv @@
// shared types and constants for the transfer eta estimator
package teta_pkg;

  localparam int unsigned PieceW = 27;
  localparam int unsigned RateW = 32;
  localparam int unsigned PiecesW = 20;
  localparam int unsigned BytesW = 47;
  localparam int unsigned TimeW = 48;
  localparam int unsigned EtaW = 46;
  localparam logic [PieceW-1:0] PieceReset = 27'd262144;
  localparam logic signed [TimeW-1:0] ZeroRateTime = -48'sd1024;
  localparam logic [EtaW-1:0] EtaMax = {EtaW{1'b1}};

  // time window length, the mean divide below is built for it
  localparam int unsigned TimeWindow = 14;

  // floor(n / 7) = (n * Recip7) >> Recip7Shift for every n below 2^51
  localparam logic [51:0] Recip7 = 52'd2573485501354570;
  localparam int unsigned Recip7Shift = 54;

  // register addresses
  localparam logic [1:0] AddrPieceSize = 2'd0;

  // control passed from sequencer to divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

@@ src/transfer_eta_estimator_unit.sv @@
// top level: transfer eta estimator with sample memories and dividers
// a new word is taken only once the last one is through; the two 64-step serial divides are the longest steps
// the time mean takes a serial reciprocal multiply, one partial product at a time; a waiting result holds the input
// reset: fills, sums and heads clear, piece_size returns to 262144
// the sample memories need no clearing pass: entries are written before read
module transfer_eta_estimator_unit #(
  parameter int unsigned RATE_WINDOW = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [teta_pkg::RateW-1:0]    rate_sample_i,
  input  logic [teta_pkg::PiecesW-1:0]  pieces_left_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          eta_known_o,
  output logic [teta_pkg::EtaW-1:0]     eta_seconds_o,
  output logic [teta_pkg::RateW-1:0]    mean_rate_o
);

  localparam int unsigned RAW = $clog2(RATE_WINDOW + 1);
  localparam int unsigned TAW = $clog2(teta_pkg::TimeWindow + 1);
  localparam int unsigned RSW = teta_pkg::RateW + RAW;
  localparam int unsigned TSW = teta_pkg::TimeW + TAW;
  localparam int unsigned AccW = 104;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRdRate = 4'd1;
  localparam logic [3:0] StRate   = 4'd2;
  localparam logic [3:0] StDivR   = 4'd3;
  localparam logic [3:0] StMul    = 4'd4;
  localparam logic [3:0] StDivT   = 4'd5;
  localparam logic [3:0] StRdTime = 4'd6;
  localparam logic [3:0] StTime   = 4'd7;
  localparam logic [3:0] StPp     = 4'd8;
  localparam logic [3:0] StQuo    = 4'd9;
  localparam logic [3:0] StMod    = 4'd10;
  localparam logic [3:0] StRound  = 4'd11;
  localparam logic [3:0] StFix    = 4'd12;
  localparam logic [3:0] StOut    = 4'd13;

  logic [3:0] st_q, st_d;

  // configuration register
  logic [teta_pkg::PieceW-1:0] piece_q;
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && (paddr == {teta_pkg::AddrPieceSize});
  assign pready = 1'b1;
  assign prdata = (paddr == teta_pkg::AddrPieceSize) ? 32'(piece_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_q <= teta_pkg::PieceReset;
    end else if (cfg_we) begin
      piece_q <= pwdata[teta_pkg::PieceW-1:0];
    end
  end

  // window state
  logic [RAW-1:0] rfill_q, rhead_q;
  logic [TAW-1:0] tfill_q, thead_q;
  logic [RSW-1:0] rsum_q;
  logic signed [TSW-1:0] tsum_q;
  logic [teta_pkg::RateW-1:0] rate_q, mean_q;
  logic [teta_pkg::PiecesW-1:0] pieces_q;
  logic [63:0] bytes_q;
  logic signed [teta_pkg::TimeW-1:0] tsamp_q;
  logic [TSW-1:0] tmag_q;
  logic tneg_q;
  logic [teta_pkg::EtaW+1:0] eta_q;
  logic known_q;
  logic [5:0] rem60_q;
  logic [1:0] pp_q;
  logic [AccW-1:0] acc_q;

  // sample memories
  logic r_we, t_we;
  logic [teta_pkg::RateW-1:0] r_rd;
  logic [teta_pkg::TimeW-1:0] t_rd;
  assign r_we = (st_q == StRate);
  assign t_we = (st_q == StTime);

  teta_ring #(.Depth(RATE_WINDOW), .DataW(teta_pkg::RateW)) u_rring (
    .clk_i, .we_i(r_we), .waddr_i(rhead_q), .wdata_i(rate_q),
    .raddr_i(rhead_q), .rdata_o(r_rd)
  );
  teta_ring #(.Depth(teta_pkg::TimeWindow), .DataW(teta_pkg::TimeW)) u_tring (
    .clk_i, .we_i(t_we), .waddr_i(thead_q), .wdata_i(tsamp_q),
    .raddr_i(thead_q), .rdata_o(t_rd)
  );

  // shared divider
  teta_pkg::div_ctl_t dctl;
  logic [63:0] dnum, dden, dquo;
  logic ddone;
  assign dctl.busy = (st_q == StDivR) || (st_q == StDivT);
  assign dctl.start = (st_q == StRate) || (st_q == StMul);

  always_comb begin
    dnum = 64'(rsum_q);
    dden = 64'(rfill_q);
    unique case (st_q)
      StRate: begin
        if (rfill_q >= RAW'(RATE_WINDOW)) begin
          dnum = 64'(rsum_q - RSW'(r_rd) + RSW'(rate_q));
          dden = 64'(rfill_q);
        end else begin
          dnum = 64'(rsum_q + RSW'(rate_q));
          dden = 64'(rfill_q + 1'b1);
        end
      end
      StMul: begin
        dnum = bytes_q;
        dden = 64'(mean_q);
      end
      default: begin
        dnum = 64'(rsum_q);
        dden = 64'(rfill_q);
      end
    endcase
  end

  teta_div #(.NumW(64), .DenW(64)) u_div (
    .clk_i, .rst_ni, .start_i(dctl.start), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  logic signed [TSW-1:0] tsum_new;
  always_comb begin
    if (tfill_q >= TAW'(teta_pkg::TimeWindow)) begin
      tsum_new = tsum_q - TSW'(signed'(t_rd)) + TSW'(tsamp_q);
    end else begin
      tsum_new = tsum_q + TSW'(tsamp_q);
    end
  end

  // time mean: |sum| / 14 as (|sum| >> 1) * Recip7, one 26x26 partial product a cycle
  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;
  logic [AccW-1:0] mul_term;
  always_comb begin
    mul_a = tmag_q[26:1];
    mul_b = teta_pkg::Recip7[25:0];
    case (pp_q)
      2'd1: begin
        mul_b = teta_pkg::Recip7[51:26];
      end
      2'd2: begin
        mul_a = {1'b0, tmag_q[TSW-1:27]};
      end
      2'd3: begin
        mul_a = {1'b0, tmag_q[TSW-1:27]};
        mul_b = teta_pkg::Recip7[51:26];
      end
      default: begin
        mul_a = tmag_q[26:1];
      end
    endcase
    mul_p = mul_a * mul_b;
    case (pp_q)
      2'd0:    mul_term = AccW'(mul_p);
      2'd3:    mul_term = AccW'(mul_p) << 52;
      default: mul_term = AccW'(mul_p) << 26;
    endcase
  end

  logic [teta_pkg::EtaW+1:0] mean_quo;
  assign mean_quo = acc_q[teta_pkg::Recip7Shift +: (teta_pkg::EtaW + 2)];

  // seconds part: fold base-64 digits, 64 is 4 modulo 60
  logic [11:0] fold1;
  logic [8:0]  fold2;
  logic [6:0]  fold3;
  logic [5:0]  rem60;
  always_comb begin
    fold1 = 12'(eta_q[5:0])
          + ((12'(eta_q[11:6]) + 12'(eta_q[23:18]) + 12'(eta_q[35:30])
             + 12'(eta_q[47:42])) << 2)
          + ((12'(eta_q[17:12]) + 12'(eta_q[29:24]) + 12'(eta_q[41:36])) << 4);
    fold2 = 9'(fold1[5:0]) + (9'(fold1[11:6]) << 2);
    fold3 = 7'(fold2[5:0]) + (7'(fold2[8:6]) << 2);
    rem60 = (fold3 >= 7'd60) ? 6'(fold3 - 7'd60) : 6'(fold3);
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:   if (in_valid_i && !out_valid_o) st_d = StRdRate;
      StRdRate: st_d = StRate;
      StRate:   st_d = StDivR;
      StDivR:   if (ddone) st_d = StMul;
      StMul:    st_d = StDivT;
      StDivT:   if (ddone || !dctl.busy) st_d = StRdTime;
      StRdTime: st_d = StTime;
      StTime:   st_d = StPp;
      StPp:     if (pp_q == 2'd3) st_d = StQuo;
      StQuo:    st_d = StMod;
      StMod:    st_d = StRound;
      StRound:  st_d = StFix;
      StFix:    st_d = StOut;
      StOut:    st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  assign in_ready_o = (st_q == StIdle) && !out_valid_o;

  logic ovalid_q;
  logic [teta_pkg::EtaW-1:0] oeta_q;
  logic [teta_pkg::RateW-1:0] omean_q;
  logic oknown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      rfill_q  <= '0;
      rhead_q  <= '0;
      rsum_q   <= '0;
      tfill_q  <= '0;
      thead_q  <= '0;
      tsum_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StRate) begin
        if (rfill_q >= RAW'(RATE_WINDOW)) begin
          rsum_q <= rsum_q - RSW'(r_rd) + RSW'(rate_q);
        end else begin
          rsum_q  <= rsum_q + RSW'(rate_q);
          rfill_q <= rfill_q + 1'b1;
        end
        rhead_q <= (rhead_q == RAW'(RATE_WINDOW - 1)) ? '0 : rhead_q + 1'b1;
      end
      if (st_q == StTime) begin
        tsum_q <= tsum_new;
        if (tfill_q >= TAW'(teta_pkg::TimeWindow)) begin
          tfill_q <= TAW'(teta_pkg::TimeWindow);
        end else begin
          tfill_q <= tfill_q + 1'b1;
        end
        thead_q <= (thead_q == TAW'(teta_pkg::TimeWindow - 1)) ? '0 : thead_q + 1'b1;
      end
      if (st_q == StOut) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // ready flag: window was full before this sample
  logic full_q;
  logic zero_mean_q;
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rate_q   <= rate_sample_i;
      pieces_q <= pieces_left_i;
    end
    if (st_q == StDivR && ddone) begin
      mean_q  <= dquo[teta_pkg::RateW-1:0];
      bytes_q <= 64'(pieces_q) * 64'(piece_q);
    end
    // zero mean rate: the divide still runs and its quotient is replaced
    if (st_q == StMul) begin
      zero_mean_q <= (mean_q == '0);
    end
    if (st_q == StDivT && ddone) begin
      tsamp_q <= zero_mean_q ? teta_pkg::ZeroRateTime
                             : signed'(dquo[teta_pkg::TimeW-1:0]);
    end
    if (st_q == StRdTime) begin
      full_q <= (tfill_q >= TAW'(teta_pkg::TimeWindow));
    end
    if (st_q == StTime) begin
      tneg_q <= tsum_new[TSW-1];
      tmag_q <= tsum_new[TSW-1] ? TSW'(-tsum_new) : TSW'(tsum_new);
      pp_q   <= '0;
      acc_q  <= '0;
    end
    if (st_q == StPp) begin
      acc_q <= acc_q + mul_term;
      pp_q  <= pp_q + 1'b1;
    end
    if (st_q == StQuo) begin
      eta_q   <= mean_quo;
      known_q <= full_q && (!tneg_q || mean_quo == '0);
    end
    if (st_q == StMod) begin
      rem60_q <= rem60;
    end
    if (st_q == StRound) begin
      if (eta_q >= (teta_pkg::EtaW+2)'(60) && rem60_q >= 6'd50) begin
        eta_q <= eta_q + (teta_pkg::EtaW+2)'(7'd60 - 7'(rem60_q));
      end
    end
    if (st_q == StFix) begin
      oknown_q <= known_q;
      omean_q  <= mean_q;
      if (!known_q) begin
        oeta_q <= '0;
      end else if (eta_q > (teta_pkg::EtaW+2)'(teta_pkg::EtaMax)) begin
        oeta_q <= teta_pkg::EtaMax;
      end else begin
        oeta_q <= eta_q[teta_pkg::EtaW-1:0];
      end
    end
  end

  assign out_valid_o   = ovalid_q;
  assign eta_known_o   = oknown_q;
  assign eta_seconds_o = oeta_q;
  assign mean_rate_o   = omean_q;

  // no new word while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken with result pending");
  // fill counters stay within their windows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rfill_q <= RAW'(RATE_WINDOW)) else $error("rate fill overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tfill_q <= TAW'(teta_pkg::TimeWindow)) else $error("time fill overrun");
  // unknown result carries zero seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !eta_known_o) |-> eta_seconds_o == '0) else $error("eta not zeroed");

endmodule

@@ src/teta_div.sv @@
// iterative unsigned restoring divider, one quotient bit per cycle
module teta_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  // shift-subtract step
  always_comb begin
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/teta_ring.sv @@
// window sample memory, one write and one registered read per cycle
module teta_ring #(
  parameter int unsigned Depth = 30,
  parameter int unsigned DataW = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth+1)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth+1)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
